// ===== src/qvr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared widths, types and register indexes of the quaternion rotation block.
// ----------------------------------------------------------------------------
package qvr_pkg;

   localparam int COORD_BITS    = 32;
   localparam int QUAT_BITS     = 16;
   localparam int QUAT_FRAC     = 14;
   localparam int MAT_FRAC      = 2 * QUAT_FRAC;
   localparam int SQ_W          = 2 * QUAT_BITS;
   // coefficients reach about 2^32 in magnitude
   localparam int MAT_W         = SQ_W + 3;
   localparam int LO_W          = COORD_BITS / 2;
   localparam int HI_W          = COORD_BITS - LO_W;
   localparam int PPLO_W        = MAT_W + LO_W + 1;
   localparam int PPHI_W        = MAT_W + HI_W;
   localparam int PROD_W        = MAT_W + COORD_BITS;
   localparam int SUM_W         = PROD_W + 2;
   localparam int SHR_W         = SUM_W - MAT_FRAC;
   localparam int NUM_AXES      = 3;
   localparam int NUM_QUAT_REGS = 4;
   localparam int CSR_IDX_W     = 4;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [QUAT_BITS-1:0]  quat_type;
   typedef logic signed [MAT_W-1:0]      coef_type;

   localparam logic [CSR_IDX_W-1:0] CSR_QUAT_W = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_QUAT_X = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_QUAT_Y = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_QUAT_Z = CSR_IDX_W'(3);

   localparam quat_type QUAT_ONE  = quat_type'(1 << QUAT_FRAC);
   localparam quat_type QUAT_ZERO = quat_type'(0);

endpackage
`default_nettype wire

// ===== src/qvr_matrix.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qvr_matrix
// Quaternion registers and the two-stage build of the 3x3 rotation matrix.
// ----------------------------------------------------------------------------
module qvr_matrix (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [qvr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  qvr_pkg::quat_type               csr_wdata,
   output qvr_pkg::coef_type               mat [qvr_pkg::NUM_AXES][qvr_pkg::NUM_AXES]
);
   import qvr_pkg::*;

   typedef logic signed [SQ_W-1:0] sq_type;
   localparam int TR_W = MAT_W + 2;

   quat_type q_ff [NUM_QUAT_REGS];
   quat_type q_in [NUM_QUAT_REGS];

   sq_type ww_ff, xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;
   coef_type mat_ff [NUM_AXES][NUM_AXES];
   coef_type mat_in [NUM_AXES][NUM_AXES];

   always_comb begin
      q_in = q_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_QUAT_W: q_in[0] = csr_wdata;
            CSR_QUAT_X: q_in[1] = csr_wdata;
            CSR_QUAT_Y: q_in[2] = csr_wdata;
            CSR_QUAT_Z: q_in[3] = csr_wdata;
            default: ;   // writes past the last register are dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff[0] <= QUAT_ONE;
         q_ff[1] <= QUAT_ZERO;
         q_ff[2] <= QUAT_ZERO;
         q_ff[3] <= QUAT_ZERO;
      end else begin
         q_ff <= q_in;
      end
   end

   // stage 1: component products
   always_ff @(posedge clock) begin
      ww_ff <= sq_type'(q_ff[0]) * sq_type'(q_ff[0]);
      xx_ff <= sq_type'(q_ff[1]) * sq_type'(q_ff[1]);
      yy_ff <= sq_type'(q_ff[2]) * sq_type'(q_ff[2]);
      zz_ff <= sq_type'(q_ff[3]) * sq_type'(q_ff[3]);
      xy_ff <= sq_type'(q_ff[1]) * sq_type'(q_ff[2]);
      xz_ff <= sq_type'(q_ff[1]) * sq_type'(q_ff[3]);
      yz_ff <= sq_type'(q_ff[2]) * sq_type'(q_ff[3]);
      wx_ff <= sq_type'(q_ff[0]) * sq_type'(q_ff[1]);
      wy_ff <= sq_type'(q_ff[0]) * sq_type'(q_ff[2]);
      wz_ff <= sq_type'(q_ff[0]) * sq_type'(q_ff[3]);
   end

   // stage 2: coefficients, Q28
   always_comb begin
      mat_in[0][0] = MAT_W'(ww_ff) + MAT_W'(xx_ff) - MAT_W'(yy_ff) - MAT_W'(zz_ff);
      mat_in[1][1] = MAT_W'(ww_ff) - MAT_W'(xx_ff) + MAT_W'(yy_ff) - MAT_W'(zz_ff);
      mat_in[2][2] = MAT_W'(ww_ff) - MAT_W'(xx_ff) - MAT_W'(yy_ff) + MAT_W'(zz_ff);
      mat_in[0][1] = (MAT_W'(xy_ff) - MAT_W'(wz_ff)) <<< 1;
      mat_in[0][2] = (MAT_W'(xz_ff) + MAT_W'(wy_ff)) <<< 1;
      mat_in[1][0] = (MAT_W'(xy_ff) + MAT_W'(wz_ff)) <<< 1;
      mat_in[1][2] = (MAT_W'(yz_ff) - MAT_W'(wx_ff)) <<< 1;
      mat_in[2][0] = (MAT_W'(xz_ff) - MAT_W'(wy_ff)) <<< 1;
      mat_in[2][1] = (MAT_W'(yz_ff) + MAT_W'(wx_ff)) <<< 1;
   end

   always_ff @(posedge clock) begin
      mat_ff <= mat_in;
   end

   assign mat = mat_ff;

   // settled-matrix checks against the register values
   logic signed [TR_W-1:0] trace_got, trace_exp, xy4_got, xy4_exp;

   assign trace_got = TR_W'(mat_ff[0][0]) + TR_W'(mat_ff[1][1]) + TR_W'(mat_ff[2][2]);
   assign trace_exp = TR_W'(3) * TR_W'(q_ff[0]) * TR_W'(q_ff[0])
                    - TR_W'(q_ff[1]) * TR_W'(q_ff[1])
                    - TR_W'(q_ff[2]) * TR_W'(q_ff[2])
                    - TR_W'(q_ff[3]) * TR_W'(q_ff[3]);
   assign xy4_got   = TR_W'(mat_ff[0][1]) + TR_W'(mat_ff[1][0]);
   assign xy4_exp   = TR_W'(4) * TR_W'(q_ff[1]) * TR_W'(q_ff[2]);

   a_trace: assert property (@(posedge clock) disable iff (reset)
      (csr_we ##1 !csr_we ##1 !csr_we) |=> (trace_got == trace_exp))
      else $error("matrix trace does not match quaternion");

   a_offdiag: assert property (@(posedge clock) disable iff (reset)
      (csr_we ##1 !csr_we ##1 !csr_we) |=> (xy4_got == xy4_exp))
      else $error("matrix off-diagonal pair does not match quaternion");

endmodule
`default_nettype wire

// ===== src/qvr_dot.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qvr_dot
// One matrix row times the point: split partial products, product merge,
// three-way sum with rounding, then saturation. Four register stages.
// ----------------------------------------------------------------------------
module qvr_dot (
   input  logic                clock,
   input  qvr_pkg::coef_type   coef   [qvr_pkg::NUM_AXES],
   input  qvr_pkg::coord_type  point  [qvr_pkg::NUM_AXES],
   output qvr_pkg::coord_type  result
);
   import qvr_pkg::*;

   localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (MAT_FRAC - 1);
   localparam logic signed [SHR_W-1:0] SAT_MAX    = (SHR_W'(1) <<< (COORD_BITS - 1)) - SHR_W'(1);
   localparam logic signed [SHR_W-1:0] SAT_MIN    = -SAT_MAX - SHR_W'(1);

   logic signed [PPLO_W-1:0] pp_lo_ff [NUM_AXES];
   logic signed [PPHI_W-1:0] pp_hi_ff [NUM_AXES];
   logic signed [PROD_W-1:0] prod_ff  [NUM_AXES];
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [SHR_W-1:0]  shr;
   coord_type                res_ff, res_in;

   // coordinate split into signed high half and unsigned low half
   always_ff @(posedge clock) begin
      for (int j = 0; j < NUM_AXES; j++) begin
         pp_lo_ff[j] <= PPLO_W'(coef[j]) * PPLO_W'($signed({1'b0, point[j][LO_W-1:0]}));
         pp_hi_ff[j] <= PPHI_W'(coef[j]) * PPHI_W'($signed(point[j][COORD_BITS-1:LO_W]));
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < NUM_AXES; j++) begin
         prod_ff[j] <= (PROD_W'(pp_hi_ff[j]) <<< LO_W) + PROD_W'(pp_lo_ff[j]);
      end
   end

   assign sum_in = SUM_W'(prod_ff[0]) + SUM_W'(prod_ff[1]) + SUM_W'(prod_ff[2]) + ROUND_HALF;

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   assign shr = sum_ff[SUM_W-1:MAT_FRAC];

   always_comb begin
      priority if (shr > SAT_MAX) begin
         res_in = {1'b0, {(COORD_BITS-1){1'b1}}};
      end else if (shr < SAT_MIN) begin
         res_in = {1'b1, {(COORD_BITS-1){1'b0}}};
      end else begin
         res_in = shr[COORD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign result = res_ff;

endmodule
`default_nettype wire

// ===== src/quaternion_vector_rotate_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_top
// Rotates Q16.16 points by the Q2.14 quaternion in the csr registers.
// ----------------------------------------------------------------------------
// rsp_valid comes from a valid shift register as deep as the data path.
// Throughput: one request per clock; busy stays low, a full pipeline of
//   point delay, split multiply, merge, sum and saturate stages sets this.
// A csr write may be followed by a request in the next cycle; the matrix
//   is built from the registers before the multiply stage reads it.
// Reset clears the valid pipeline and loads the identity quaternion.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  qvr_pkg::coord_type             req_point_x,
   input  qvr_pkg::coord_type             req_point_y,
   input  qvr_pkg::coord_type             req_point_z,
   output logic                           rsp_valid,
   output qvr_pkg::coord_type             rsp_rotated_x,
   output qvr_pkg::coord_type             rsp_rotated_y,
   output qvr_pkg::coord_type             rsp_rotated_z,
   input  logic                           csr_we,
   input  logic [qvr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  qvr_pkg::quat_type              csr_wdata
);
   import qvr_pkg::*;

   localparam int PIPE_DEPTH = 7;

   logic                  accept;
   logic [PIPE_DEPTH-1:0] valid_ff, valid_in;
   coord_type             pt1_ff [NUM_AXES];
   coord_type             pt2_ff [NUM_AXES];
   coord_type             pt3_ff [NUM_AXES];
   coord_type             res    [NUM_AXES];
   coef_type              mat    [NUM_AXES][NUM_AXES];

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign valid_in = {valid_ff[PIPE_DEPTH-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // point waits while the matrix of a fresh csr write settles
   always_ff @(posedge clock) begin
      pt1_ff[0] <= req_point_x;
      pt1_ff[1] <= req_point_y;
      pt1_ff[2] <= req_point_z;
      pt2_ff    <= pt1_ff;
      pt3_ff    <= pt2_ff;
   end

   qvr_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .mat       (mat)
   );

   for (genvar i = 0; i < NUM_AXES; i++) begin : g_row
      qvr_dot u_dot (
         .clock  (clock),
         .coef   (mat[i]),
         .point  (pt3_ff),
         .result (res[i])
      );
   end

   assign rsp_valid     = valid_ff[PIPE_DEPTH-1];
   assign rsp_rotated_x = res[0];
   assign rsp_rotated_y = res[1];
   assign rsp_rotated_z = res[2];

   // an accepted request is always followed by its rsp_valid
   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(PIPE_DEPTH) rsp_valid)
      else $error("accepted request produced no response");

   a_resp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, PIPE_DEPTH))
      else $error("response without a matching request");

endmodule
`default_nettype wire

// ===== verif/tb_quaternion_vector_rotate_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quaternion_vector_rotate_top
// Self-checking bench for the quaternion point rotator. A directed table
// covers reset values, ignored register writes, exact scaling, rounding ties
// and saturation. Random phases follow, each with a new quaternion. Each
// accepted request is predicted with full-width integer math or taken from
// the table, and matched against the response stream in order.
// ----------------------------------------------------------------------------
module tb_quaternion_vector_rotate_top;
   import qvr_pkg::*;

   localparam int GAP_PERCENT      = 29;
   localparam int RANDOM_PHASES    = 16;
   localparam int POINTS_PER_PHASE = 96;
   localparam int SETTLE_CYCLES    = 20;
   localparam int ACC_W            = 96;
   localparam longint TWICE        = 2;

   localparam coord_type COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
   localparam quat_type  QUAT_MAX  = {1'b0, {(QUAT_BITS-1){1'b1}}};
   localparam quat_type  QUAT_MIN  = {1'b1, {(QUAT_BITS-1){1'b0}}};
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_UNUSED = CSR_IDX_W'(NUM_QUAT_REGS);
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_UNUSED  = '1;
   localparam logic signed [ACC_W-1:0] ROUND_HALF    = ACC_W'(1) <<< (MAT_FRAC - 1);

   typedef coord_type [NUM_AXES-1:0] vec3_type;

   typedef enum logic [1:0] {ROW_CSR, ROW_POINT, ROW_POINT_KNOWN} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  index;
      quat_type              data;
      vec3_type              point;
      vec3_type              known;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   coord_type             req_point_x;
   coord_type             req_point_y;
   coord_type             req_point_z;
   logic                  rsp_valid;
   coord_type             rsp_rotated_x;
   coord_type             rsp_rotated_y;
   coord_type             rsp_rotated_z;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   quat_type              csr_wdata;

   // predictor copy of the quaternion registers
   quat_type  quat_w = QUAT_ONE;
   quat_type  quat_x = QUAT_ZERO;
   quat_type  quat_y = QUAT_ZERO;
   quat_type  quat_z = QUAT_ZERO;

   vec3_type     expected_rotations[$];
   stim_row_type directed_rows[$];
   bit           gaps_on = 1'b1;
   int           mismatch_count = 0;

   quaternion_vector_rotate_top dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_point_x   (req_point_x),
      .req_point_y   (req_point_y),
      .req_point_z   (req_point_z),
      .rsp_valid     (rsp_valid),
      .rsp_rotated_x (rsp_rotated_x),
      .rsp_rotated_y (rsp_rotated_y),
      .rsp_rotated_z (rsp_rotated_z),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("quaternion_vector_rotate_top: mismatch");
      $finish;
   end

   function automatic vec3_type vec(coord_type x, coord_type y, coord_type z);
      vec3_type v;
      v[0] = x;
      v[1] = y;
      v[2] = z;
      return v;
   endfunction

   // Rotation matrix from the current quaternion, Q28 coefficients, then
   // one rounding of the exact dot product and a clamp to the coord range.
   function automatic vec3_type rotate_point(vec3_type pt);
      longint w, x, y, z, s;
      longint coef [NUM_AXES][NUM_AXES];
      logic signed [ACC_W-1:0] acc;
      vec3_type res;
      int r, k;
      w = longint'(quat_w);
      x = longint'(quat_x);
      y = longint'(quat_y);
      z = longint'(quat_z);
      s = w * w - (x * x + y * y + z * z);
      coef[0][0] = s + TWICE * x * x;
      coef[0][1] = TWICE * x * y - TWICE * w * z;
      coef[0][2] = TWICE * x * z + TWICE * w * y;
      coef[1][0] = TWICE * x * y + TWICE * w * z;
      coef[1][1] = s + TWICE * y * y;
      coef[1][2] = TWICE * y * z - TWICE * w * x;
      coef[2][0] = TWICE * x * z - TWICE * w * y;
      coef[2][1] = TWICE * y * z + TWICE * w * x;
      coef[2][2] = s + TWICE * z * z;
      for (r = 0; r < NUM_AXES; r++) begin
         acc = ROUND_HALF;
         for (k = 0; k < NUM_AXES; k++)
            acc = acc + ACC_W'(coef[r][k]) * ACC_W'($signed(pt[k]));
         acc = acc >>> MAT_FRAC;
         if (acc > ACC_W'(COORD_MAX))
            res[r] = COORD_MAX;
         else if (acc < ACC_W'(COORD_MIN))
            res[r] = COORD_MIN;
         else
            res[r] = acc[COORD_BITS-1:0];
      end
      return res;
   endfunction

   function automatic stim_row_type csr_row(logic [CSR_IDX_W-1:0] idx, quat_type val);
      stim_row_type row;
      row.kind  = ROW_CSR;
      row.index = idx;
      row.data  = val;
      row.point = '0;
      row.known = '0;
      return row;
   endfunction

   function automatic stim_row_type point_row(coord_type x, coord_type y, coord_type z);
      stim_row_type row;
      row.kind  = ROW_POINT;
      row.index = '0;
      row.data  = '0;
      row.point = vec(x, y, z);
      row.known = '0;
      return row;
   endfunction

   function automatic stim_row_type known_row(coord_type x, coord_type y, coord_type z,
                                              coord_type ex, coord_type ey, coord_type ez);
      stim_row_type row;
      row = point_row(x, y, z);
      row.kind  = ROW_POINT_KNOWN;
      row.known = vec(ex, ey, ez);
      return row;
   endfunction

   function automatic quat_type pick_quat(int phase);
      if (phase == 0)
         return QUAT_MAX;
      if (phase == 1)
         return QUAT_MIN;
      case ($urandom_range(0, 7))
         0:       return QUAT_MAX;
         1:       return QUAT_MIN;
         2:       return QUAT_ZERO;
         3:       return QUAT_ONE;
         4:       return -QUAT_ONE;
         default: return quat_type'($urandom);
      endcase
   endfunction

   function automatic coord_type pick_coord();
      case ($urandom_range(0, 7))
         0:       return COORD_MAX;
         1:       return COORD_MIN;
         2:       return coord_type'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
         3:       return coord_type'($urandom_range(0, 6)) - 32'sd3;
         default: return coord_type'($urandom);
      endcase
   endfunction

   // lower start and wait for every outstanding request to come back
   task automatic drain();
      start <= 1'b0;
      while (expected_rotations.size() != 0)
         @(posedge clock);
   endtask

   // csr_we stays high across back-to-back writes; send_point lowers it
   task automatic write_quat_reg(logic [CSR_IDX_W-1:0] idx, quat_type val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == CSR_QUAT_W)
         quat_w = val;
      else if (idx == CSR_QUAT_X)
         quat_x = val;
      else if (idx == CSR_QUAT_Y)
         quat_y = val;
      else if (idx == CSR_QUAT_Z)
         quat_z = val;
   endtask

   task automatic send_point(vec3_type pt, bit use_known, vec3_type known);
      csr_we <= 1'b0;
      while (gaps_on && $urandom_range(0, 99) < GAP_PERCENT) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start       <= 1'b1;
      req_point_x <= pt[0];
      req_point_y <= pt[1];
      req_point_z <= pt[2];
      do
         @(posedge clock);
      while (busy !== 1'b0);
      expected_rotations.push_back(use_known ? known : rotate_point(pt));
   endtask

   always @(posedge clock) begin
      vec3_type exp_v;
      vec3_type got_v;
      int a;
      if (!reset && rsp_valid !== 1'b0) begin
         got_v = vec(rsp_rotated_x, rsp_rotated_y, rsp_rotated_z);
         if (expected_rotations.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected response, actual %h %h %h", $time,
                     got_v[0], got_v[1], got_v[2]);
         end else begin
            exp_v = expected_rotations.pop_front();
            for (a = 0; a < NUM_AXES; a++) begin
               if (got_v[a] !== exp_v[a] || rsp_valid !== 1'b1) begin
                  mismatch_count++;
                  $display("%0t: rotated axis %0d expected %h actual %h", $time, a,
                           exp_v[a], got_v[a]);
               end
            end
         end
      end
   end

   initial begin
      stim_row_type row;
      int phase, n;
      reset       <= 1'b1;
      start       <= 1'b0;
      req_point_x <= '0;
      req_point_y <= '0;
      req_point_z <= '0;
      csr_we      <= 1'b0;
      csr_index   <= '0;
      csr_wdata   <= '0;

      // reset quaternion is identity; an unused index must not disturb it
      directed_rows.push_back(csr_row(CSR_LAST_UNUSED, 16'sh5a5a));
      directed_rows.push_back(known_row(0, 0, 0, 0, 0, 0));
      directed_rows.push_back(known_row(COORD_MAX, COORD_MIN, 1, COORD_MAX, COORD_MIN, 1));
      directed_rows.push_back(known_row(COORD_MIN, COORD_MAX, -1, COORD_MIN, COORD_MAX, -1));
      directed_rows.push_back(known_row(32'h1234_5678, 32'hdead_beef, 32'h0001_0000,
                                        32'h1234_5678, 32'hdead_beef, 32'h0001_0000));
      // w = -2.0: exact scale by four, clamps at both ends
      directed_rows.push_back(csr_row(CSR_QUAT_W, QUAT_MIN));
      directed_rows.push_back(known_row(1, -1, 32'h0001_0000, 4, -4, 32'h0004_0000));
      directed_rows.push_back(known_row(COORD_MAX, COORD_MIN, 32'h2000_0000,
                                        COORD_MAX, COORD_MIN, COORD_MAX));
      // w = 0.5: scale by a quarter, half-way cases round up
      directed_rows.push_back(csr_row(CSR_QUAT_W, 16'sh2000));
      directed_rows.push_back(known_row(2, -2, 6, 1, 0, 2));
      directed_rows.push_back(known_row(-6, 3, -3, -1, 1, -1));
      // half turn about x: y and z negate, most negative z clamps high
      directed_rows.push_back(csr_row(CSR_QUAT_W, QUAT_ZERO));
      directed_rows.push_back(csr_row(CSR_QUAT_X, QUAT_ONE));
      directed_rows.push_back(known_row(5, 7, COORD_MIN, 5, -7, COORD_MAX));
      // extreme components
      directed_rows.push_back(csr_row(CSR_QUAT_W, QUAT_MAX));
      directed_rows.push_back(csr_row(CSR_QUAT_X, QUAT_MAX));
      directed_rows.push_back(csr_row(CSR_QUAT_Y, QUAT_MIN));
      directed_rows.push_back(csr_row(CSR_QUAT_Z, QUAT_MAX));
      directed_rows.push_back(point_row(COORD_MAX, COORD_MAX, COORD_MAX));
      directed_rows.push_back(point_row(COORD_MIN, COORD_MIN, COORD_MIN));
      directed_rows.push_back(point_row(32'h0001_0000, 32'hfffe_8000, 32'h0000_0123));
      // about a quarter turn around z
      directed_rows.push_back(csr_row(CSR_QUAT_W, 16'sh2d41));
      directed_rows.push_back(csr_row(CSR_QUAT_X, QUAT_ZERO));
      directed_rows.push_back(csr_row(CSR_QUAT_Y, QUAT_ZERO));
      directed_rows.push_back(csr_row(CSR_QUAT_Z, 16'sh2d41));
      directed_rows.push_back(point_row(32'h0001_0000, 0, 0));
      directed_rows.push_back(point_row(0, 32'h0001_0000, 32'h0002_0000));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         case (row.kind)
            ROW_CSR: begin
               drain();
               write_quat_reg(row.index, row.data);
            end
            ROW_POINT:       send_point(row.point, 1'b0, '0);
            ROW_POINT_KNOWN: send_point(row.point, 1'b1, row.known);
            default: ;
         endcase
      end

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain();
         // a few phases stream back to back with no gaps
         gaps_on = (phase < 5 || phase > 7);
         if ($urandom_range(0, 3) == 0)
            write_quat_reg(CSR_IDX_W'($urandom_range(CSR_FIRST_UNUSED, CSR_LAST_UNUSED)),
                           quat_type'($urandom));
         write_quat_reg(CSR_QUAT_W, pick_quat(phase));
         write_quat_reg(CSR_QUAT_X, pick_quat(phase));
         write_quat_reg(CSR_QUAT_Y, pick_quat(phase));
         write_quat_reg(CSR_QUAT_Z, pick_quat(phase));
         for (n = 0; n < POINTS_PER_PHASE; n++)
            send_point(vec(pick_coord(), pick_coord(), pick_coord()), 1'b0, '0);
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("quaternion_vector_rotate_top: match");
      else
         $display("quaternion_vector_rotate_top: mismatch");
      $finish;
   end

endmodule

// ===== sim.f =====
src/qvr_pkg.sv
src/qvr_matrix.sv
src/qvr_dot.sv
src/quaternion_vector_rotate_top.sv
verif/tb_quaternion_vector_rotate_top.sv
